>>> rtl/ord_pkg.sv
// Types and codes shared by the object record deframer modules.
// Depends on nothing; every other file of the block imports it.
package ord_pkg;

  // Record header
  localparam int unsigned HeaderBytes = 4;
  localparam logic [7:0]  LeadByte    = 8'h01;
  localparam logic [7:0]  SecondByte  = 8'h00;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SECOND  = 3'd1,
    PH_LENLO   = 3'd2,
    PH_LENHI   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5,
    PH_DEAD    = 3'd6
  } phase_e;

  // Result kind
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Error code
  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_LEAD   = 3'd1,
    ERR_SECOND = 3'd2,
    ERR_SHORT  = 3'd3,
    ERR_TRUNC  = 3'd4,
    ERR_SUM    = 3'd5
  } err_e;

  // Input request: one stream byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_req_t;

  // Result request
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    err_e        error_code;
  } out_res_t;

endpackage

>>> rtl/ord_in_stage.sv
// Input register of the object record deframer: holds one byte request.
// Depends on ord_pkg.
module ord_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ord_pkg::in_req_t in_req_i,
  input  logic            out_free_i,
  output logic            s1_valid_o,
  output ord_pkg::in_req_t s1_req_o
);
  import ord_pkg::*;

  logic    s1_valid_q, s1_valid_d;
  in_req_t s1_req_q;
  logic    load;

  // Stall only while a held request cannot move on
  assign in_stall_o = s1_valid_q && !out_free_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Capture the payload on acceptance
  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_req_q <= in_req_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_req_o   = s1_req_q;
endmodule

>>> rtl/ord_fsm.sv
// Record parser state machine: header check, length count, checksum.
// Depends on ord_pkg.
module ord_fsm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  ord_pkg::in_req_t req_i,
  output logic             res_valid_o,
  output ord_pkg::out_res_t res_o,
  output logic             dead_o
);
  import ord_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [7:0]  running_sum_q, running_sum_d;
  logic [7:0]  length_low_q, length_low_d;
  logic [15:0] record_length_q, record_length_d;

  logic [7:0]  b;
  logic        eoi;
  logic [7:0]  sum_plus;
  logic [15:0] total;
  logic        too_short;
  logic [15:0] rec_len;
  logic [15:0] left_dec;

  assign b         = req_i.in_byte;
  assign eoi       = req_i.end_of_input;
  assign sum_plus  = running_sum_q + b;
  assign total     = {b, length_low_q};
  assign too_short = total < 16'(HeaderBytes);
  assign rec_len   = total - 16'(HeaderBytes);
  assign left_dec  = bytes_left_q - 16'd1;

  // Next state
  always_comb begin
    phase_d         = phase_q;
    bytes_left_d    = bytes_left_q;
    running_sum_d   = running_sum_q;
    length_low_d    = length_low_q;
    record_length_d = record_length_q;
    if (eoi) begin
      if (phase_q != PH_HUNT && phase_q != PH_DEAD) begin
        phase_d = PH_DEAD;
      end
    end else begin
      unique case (phase_q)
        PH_HUNT: begin
          if (b == LeadByte) begin
            running_sum_d = LeadByte;
            phase_d       = PH_SECOND;
          end else if (b != 8'h00) begin
            phase_d = PH_DEAD;
          end
        end
        PH_SECOND: begin
          phase_d = (b == SecondByte) ? PH_LENLO : PH_DEAD;
        end
        PH_LENLO: begin
          length_low_d  = b;
          running_sum_d = sum_plus;
          phase_d       = PH_LENHI;
        end
        PH_LENHI: begin
          running_sum_d = sum_plus;
          if (too_short) begin
            phase_d = PH_DEAD;
          end else begin
            record_length_d = rec_len;
            bytes_left_d    = rec_len;
            phase_d         = (rec_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          running_sum_d = sum_plus;
          bytes_left_d  = left_dec;
          if (left_dec == 16'd0) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (sum_plus != 8'h00) begin
            phase_d = PH_DEAD;
          end else begin
            running_sum_d = 8'h00;
            phase_d       = PH_HUNT;
          end
        end
        default: begin
          phase_d = PH_DEAD;
        end
      endcase
    end
  end

  // Result for the byte in hand
  always_comb begin
    res_valid_o          = 1'b0;
    res_o.kind           = KIND_BYTE;
    res_o.payload_byte   = 8'h00;
    res_o.payload_length = 16'd0;
    res_o.error_code     = ERR_NONE;
    if (eoi) begin
      if (phase_q != PH_HUNT && phase_q != PH_DEAD) begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = ERR_TRUNC;
      end
    end else begin
      unique case (phase_q)
        PH_HUNT: begin
          if (b != LeadByte && b != 8'h00) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_LEAD;
          end
        end
        PH_SECOND: begin
          if (b != SecondByte) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_SECOND;
          end
        end
        PH_LENHI: begin
          if (too_short) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_SHORT;
          end
        end
        PH_PAYLOAD: begin
          res_valid_o        = 1'b1;
          res_o.payload_byte = b;
        end
        PH_CHECK: begin
          res_valid_o = 1'b1;
          if (sum_plus != 8'h00) begin
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_SUM;
          end else begin
            res_o.kind           = KIND_END;
            res_o.payload_length = record_length_q;
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  // Advance only on a consumed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HUNT;
      bytes_left_q    <= 16'd0;
      running_sum_q   <= 8'h00;
      length_low_q    <= 8'h00;
      record_length_q <= 16'd0;
    end else if (step_en_i) begin
      phase_q         <= phase_d;
      bytes_left_q    <= bytes_left_d;
      running_sum_q   <= running_sum_d;
      length_low_q    <= length_low_d;
      record_length_q <= record_length_d;
    end
  end

  assign dead_o = (phase_q != PH_HUNT) && (phase_q != PH_SECOND) &&
                  (phase_q != PH_LENLO) && (phase_q != PH_LENHI) &&
                  (phase_q != PH_PAYLOAD) && (phase_q != PH_CHECK);
endmodule

>>> rtl/object_record_deframer_unit.sv
// Top level of the object record deframer: input register, parser, result register.
// Depends on ord_pkg, ord_in_stage and ord_fsm.
//
// Usage: bytes of a formatted binary object stream enter on the in channel,
// one request per cycle while in_stall_o is low (in_valid_i, in_stall_o,
// in_req_i). A request with end_of_input set marks the end of the stream. The out
// channel (out_valid_o, out_stall_i, out_res_o) gives one result per payload byte,
// a record-end result with the payload length after a good checksum, or a
// single error result, after which all further input is dropped until reset.
// Throughput: one byte per cycle while out_stall_i does not hold a result. An
// accepted byte is held in the input register, parsed by the state machine, and
// its result is loaded into the result register.
// Header and length bytes give no result unless they are in error; the checksum
// byte gives the record-end result or the checksum error.
// Reset clears both registers' valid flags and puts the parser back to
// hunting for a lead byte. While out_stall_i holds a result, one more byte
// is still taken into the input register; in_stall_o then rises until the
// result is taken.
module object_record_deframer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ord_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ord_pkg::out_res_t out_res_o
);
  import ord_pkg::*;

  logic     out_free;
  logic     s1_valid;
  in_req_t  s1_req;
  logic     step_en;
  logic     res_valid;
  out_res_t res;
  logic     dead;
  logic     out_valid_q, out_valid_d;
  out_res_t out_res_q;

  // Result register is free when empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;
  assign step_en  = s1_valid && out_free;

  ord_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_free_i (out_free),
    .s1_valid_o (s1_valid),
    .s1_req_o   (s1_req)
  );

  ord_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .req_i       (s1_req),
    .res_valid_o (res_valid),
    .res_o       (res),
    .dead_o      (dead)
  );

  // Load a new result or drop the taken one
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = step_en && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef SYNTHESIS
  // Upstream is held back only while a request waits in the input register
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid)
    else $error("input stalled with no held request");

  // An error result leaves the parser dead
  a_error_kills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && res_valid && res.kind == KIND_ERROR) |=> dead)
    else $error("parser still live after an error");

  // A dead parser gives no further result
  a_dead_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dead |-> !res_valid)
    else $error("result after error");

  // Record end carries no byte and no error code
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.kind == KIND_END) |->
      (out_res_o.payload_byte == 8'h00 && out_res_o.error_code == ERR_NONE))
    else $error("malformed record-end result");
`endif
endmodule

>>> bench/tb_object_record_deframer_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for object_record_deframer_unit: random object records in, results checked.
// Depends on ord_pkg and the deframer RTL; holds its own scoreboard class.
module tb_object_record_deframer_unit;
  import ord_pkg::*;

  // Tracks the record parser and holds the results it predicts
  class record_scoreboard;
    phase_e      phase;
    logic [15:0] bytes_left;
    logic [15:0] record_len;
    logic [7:0]  sum;
    logic [7:0]  len_low;
    out_res_t    due[$];
    int          failures;

    function new();
      phase      = PH_HUNT;
      bytes_left = '0;
      record_len = '0;
      sum        = '0;
      len_low    = '0;
      failures   = 0;
    endfunction

    function void queue_result(kind_e k, logic [7:0] b, logic [15:0] n, err_e e);
      out_res_t r;
      r.kind           = k;
      r.payload_byte   = b;
      r.payload_length = n;
      r.error_code     = e;
      due.push_back(r);
    endfunction

    // Flag an error and go dead until reset
    function void abort(err_e e);
      phase = PH_DEAD;
      queue_result(KIND_ERROR, 8'h00, 16'h0000, e);
    endfunction

    // Advance the parser by one accepted request
    function void take_byte(in_req_t r);
      logic [7:0]  b;
      logic [15:0] total;
      b     = r.in_byte;
      total = {b, len_low};
      if (phase == PH_DEAD) return;
      if (r.end_of_input) begin
        if (phase != PH_HUNT) abort(ERR_TRUNC);
        return;
      end
      case (phase)
        PH_HUNT: begin
          if (b == LeadByte) begin
            sum   = LeadByte;
            phase = PH_SECOND;
          end else if (b != 8'h00) begin
            abort(ERR_LEAD);
          end
        end
        PH_SECOND: begin
          if (b != SecondByte) abort(ERR_SECOND);
          else phase = PH_LENLO;
        end
        PH_LENLO: begin
          len_low = b;
          sum     = sum + b;
          phase   = PH_LENHI;
        end
        PH_LENHI: begin
          sum = sum + b;
          if (total < 16'(HeaderBytes)) begin
            abort(ERR_SHORT);
          end else begin
            record_len = total - 16'(HeaderBytes);
            bytes_left = record_len;
            phase      = (record_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum        = sum + b;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) phase = PH_CHECK;
          queue_result(KIND_BYTE, b, 16'h0000, ERR_NONE);
        end
        PH_CHECK: begin
          if (8'(sum + b) != 8'h00) begin
            abort(ERR_SUM);
          end else begin
            sum   = 8'h00;
            phase = PH_HUNT;
            queue_result(KIND_END, 8'h00, record_len, ERR_NONE);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(out_res_t got);
      out_res_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind=%0d byte=%h len=%0d err=%0d",
                 $time, got.kind, got.payload_byte, got.payload_length, got.error_code);
        failures++;
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: kind mismatch, expected %0d, actual %0d", $time, want.kind, got.kind);
        failures++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $display("%0t: payload_byte mismatch, expected %h, actual %h",
                 $time, want.payload_byte, got.payload_byte);
        failures++;
      end
      if (got.payload_length !== want.payload_length) begin
        $display("%0t: payload_length mismatch, expected %0d, actual %0d",
                 $time, want.payload_length, got.payload_length);
        failures++;
      end
      if (got.error_code !== want.error_code) begin
        $display("%0t: error_code mismatch, expected %0d, actual %0d",
                 $time, want.error_code, got.error_code);
        failures++;
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_req_t   in_req_i    = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_res_t  out_res_o;

  record_scoreboard sb;
  int unsigned burst_left   = 0;
  bit          gaps_on      = 1'b0;
  int unsigned record_bytes = 0;
  int unsigned stall_mode   = 0;
  int unsigned mode_left    = 0;

  object_record_deframer_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always #2 clk_i = ~clk_i;

  // Stall the result side on a pattern that changes mode now and then
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      2:       out_stall_i <= ($urandom_range(0, 7) != 0);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  // Check every result taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_res_o);
  end

  // Offer one request in bursts, with random gaps when gaps_on is set; hold it until taken
  task automatic push_request(input in_req_t r);
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (gaps_on) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    in_req_i   = r;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_byte(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_req_t r;
    r.in_byte      = b;
    r.end_of_input = 1'b0;
    push_request(r);
  endtask

  task automatic send_eoi();
    in_req_t r;
    r.in_byte      = 8'($urandom);
    r.end_of_input = 1'b1;
    push_request(r);
  endtask

  // Build and send one record; skew spoils the checksum, cut > 0 truncates
  task automatic send_record(input int unsigned plen, input logic [7:0] skew,
                             input int unsigned cut, input bit extremes);
    logic [7:0]  rec[$];
    logic [7:0]  total_sum;
    logic [15:0] total;
    int unsigned i;
    total = 16'(plen + HeaderBytes);
    rec.push_back(LeadByte);
    rec.push_back(SecondByte);
    rec.push_back(total[7:0]);
    rec.push_back(total[15:8]);
    for (i = 0; i < plen; i++) begin
      rec.push_back(extremes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom));
    end
    total_sum = 8'h00;
    foreach (rec[k]) total_sum = total_sum + rec[k];
    rec.push_back(8'(8'h00 - total_sum + skew));
    record_bytes += rec.size();
    if (cut == 0) begin
      foreach (rec[k]) send_byte(rec[k]);
    end else begin
      for (i = 0; i < cut; i++) send_byte(rec[i]);
      send_eoi();
    end
  endtask

  // Drop valid and hold off until every predicted result has come
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned plen;
    int unsigned pick;
    int unsigned recs;
    err_e        fault;
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: idle zeros, clean end while hunting, empty record, extreme payload bytes
    send_byte(8'h00);
    send_eoi();
    send_record(0, 8'h00, 0, 1'b0);
    send_record(2, 8'h00, 0, 1'b1);
    send_byte(8'h00);
    send_eoi();
    wait_drained();

    // Random well-formed records, zero filler and clean ends between them
    recs = 0;
    while (record_bytes < 1450) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'h00);
      end else if (pick == 1) begin
        send_eoi();
      end else begin
        gaps_on = ($urandom_range(0, 3) != 0);
        pick    = $urandom_range(0, 9);
        if (pick < 6)      plen = $urandom_range(0, 12);
        else if (pick < 9) plen = $urandom_range(13, 80);
        else               plen = $urandom_range(81, 600);
        send_record(plen, 8'h00, 0, 1'b0);
        recs++;
        if (recs % 20 == 0) wait_drained();
      end
    end

    // Record whose length has a zero low byte and a nonzero high byte, sent without gaps
    gaps_on = 1'b0;
    send_record(32'h0100 - HeaderBytes, 8'h00, 0, 1'b0);
    wait_drained();

    // Finish with one fault of a random kind, then show input is dropped
    gaps_on = 1'b1;
    fault   = err_e'(3'($urandom_range(1, 5)));
    case (fault)
      ERR_LEAD: send_byte(8'($urandom_range(2, 255)));
      ERR_SECOND: begin
        send_byte(LeadByte);
        send_byte(8'($urandom_range(1, 255)));
      end
      ERR_SHORT: begin
        send_byte(LeadByte);
        send_byte(SecondByte);
        send_byte(8'($urandom_range(0, HeaderBytes - 1)));
        send_byte(8'h00);
      end
      ERR_TRUNC: begin
        plen = $urandom_range(0, 10);
        send_record(plen, 8'h00, $urandom_range(1, plen + HeaderBytes), 1'b0);
      end
      default: send_record($urandom_range(0, 20), 8'($urandom_range(1, 255)), 0, 1'b0);
    endcase
    repeat (10) begin
      if ($urandom_range(0, 3) == 0) send_eoi();
      else send_byte(8'($urandom));
    end

    // Drain, allow the pipeline to settle, then report
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
